@@ design/serial_rtc_gpio_slave_assert.svh @@
// Assertion macros for the serial RTC slave checker.
// Needs clk and rst_n in the scope of each use.
`ifndef SERIAL_RTC_GPIO_SLAVE_ASSERT_SVH
`define SERIAL_RTC_GPIO_SLAVE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define SRTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SRTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after a reset edge.
`define SRTC_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

@@ design/srtc_pkg.sv @@
// Shared types, constants and helper functions for the serial RTC slave.
// No dependencies.
`timescale 1ns / 1ps

package srtc_pkg;

  localparam logic [31:0] RTC_ADDR        = 32'h0400_0138;
  localparam logic [3:0]  CMD_PLAIN_NIB   = 4'b0110;
  localparam logic [7:0]  CTRL_MASK       = 8'h0E;
  localparam logic [4:0]  HOURS_24        = 5'd24;
  localparam logic [4:0]  HOURS_12        = 5'd12;
  localparam int          LATCH_BITS      = 64;
  localparam int          CNT_W           = $clog2(LATCH_BITS) + 1;
  localparam int          IDX_W           = $clog2(LATCH_BITS);
  localparam logic [2:0]  WEEKDAY_SUNDAY  = 3'd0;
  localparam logic [2:0]  WEEKDAY_REMAP   = 3'd6;

  localparam logic [2:0]  REG_CONTROL     = 3'd0;
  localparam logic [2:0]  REG_DATETIME    = 3'd2;
  localparam logic [2:0]  REG_TIME        = 3'd3;
  localparam logic [2:0]  REG_ZERO        = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COMMAND = 2'd1,
    PH_READ    = 2'd2,
    PH_WRITE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
    logic [7:0]  write_value;
    logic [6:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       transfer_active;
  } out_item_t;

  typedef struct packed {
    logic [31:0] date_word;
    logic [23:0] time_word;
  } time_words_t;

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {8'b0, v} * 15'd205;
    tens  = prod[14:11];
    units = v - ({3'b0, tens} * 7'd10);
    return {tens, units[3:0]};
  endfunction

  function automatic logic [7:0] flip_byte(input logic [7:0] a);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = a[i];
    end
    return r;
  endfunction

endpackage

@@ design/srtc_if.sv @@
// Valid/ready channel interfaces for the serial RTC slave.
// Depends on srtc_pkg for nothing but field widths kept in step with it.
`timescale 1ns / 1ps

interface srtc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] address;
  logic [7:0]  write_value;
  logic [6:0]  year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, action, address, write_value, year, month, day,
                  weekday, hour, minute, second, input ready);
  modport sink   (input valid, action, address, write_value, year, month, day,
                  weekday, hour, minute, second, output ready);
endinterface

interface srtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       transfer_active;

  modport source (output valid, read_data, transfer_active, input ready);
  modport sink   (input valid, read_data, transfer_active, output ready);
endinterface

@@ design/srtc_time_fmt.sv @@
// BCD date and time words built from the binary time fields.
// Depends on srtc_pkg.
`timescale 1ns / 1ps

module srtc_time_fmt (
  input  srtc_pkg::in_item_t    item,
  input  logic                  mode_24h,
  output srtc_pkg::time_words_t words
);

  logic [2:0] wd_fix;
  logic [4:0] hr_mod;
  logic       pm;
  logic [7:0] hour_byte;

  always_comb begin
    wd_fix = (item.weekday == srtc_pkg::WEEKDAY_SUNDAY) ? srtc_pkg::WEEKDAY_REMAP
                                                        : item.weekday;
    if (item.hour >= srtc_pkg::HOURS_24) begin
      hr_mod = item.hour - srtc_pkg::HOURS_24;
    end else if (!mode_24h && item.hour >= srtc_pkg::HOURS_12) begin
      hr_mod = item.hour - srtc_pkg::HOURS_12;
    end else begin
      hr_mod = item.hour;
    end
    pm        = (item.hour >= srtc_pkg::HOURS_12) && (item.hour < srtc_pkg::HOURS_24);
    hour_byte = srtc_pkg::to_bcd({2'b0, hr_mod}) | {pm, 7'b0};

    words.date_word = {5'b0, wd_fix,
                       srtc_pkg::to_bcd({2'b0, item.day}),
                       srtc_pkg::to_bcd({3'b0, item.month}),
                       srtc_pkg::to_bcd(item.year)};
    words.time_word = {srtc_pkg::to_bcd({1'b0, item.second}),
                       srtc_pkg::to_bcd({1'b0, item.minute}),
                       hour_byte};
  end

endmodule

@@ design/srtc_engine.sv @@
// Pin register, serial transfer state machine and shift latch.
// Depends on srtc_pkg; fed by srtc_time_fmt.
`timescale 1ns / 1ps

module srtc_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  srtc_pkg::in_item_t    item,
  input  srtc_pkg::time_words_t words,
  output logic                  mode_24h,
  output srtc_pkg::out_item_t   result
);

  logic [7:0]                   pin_r, pin_nxt;
  logic                         dir_r, dir_nxt;
  srtc_pkg::phase_t             phase_r, phase_nxt;
  logic [srtc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]                   cmd_r, cmd_nxt;
  logic [srtc_pkg::LATCH_BITS-1:0] latch_r, latch_nxt;
  logic [7:0]                   ctrl_r, ctrl_nxt;

  logic       hit;
  logic [7:0] val;
  logic       cs_rise, cs_fall, sck_fall;
  logic [7:0] cmd_acc, cmd_fin;
  logic       cnt_live;
  logic [7:0] rd;

  assign mode_24h = ctrl_r[1];

  always_comb begin
    pin_nxt   = pin_r;
    dir_nxt   = dir_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    latch_nxt = latch_r;
    ctrl_nxt  = ctrl_r;
    rd        = 8'h00;
    hit       = (item.address == srtc_pkg::RTC_ADDR);
    val       = item.write_value;
    if (!item.write_value[4]) begin
      val[0] = pin_r[0];
    end
    cs_rise   = !pin_r[2] && val[2];
    cs_fall   = pin_r[2] && !val[2];
    sck_fall  = pin_r[1] && !val[1];
    cmd_acc   = cmd_r | ({7'b0, val[0]} << cnt_r[2:0]);
    cmd_fin   = (cmd_acc[7:4] == srtc_pkg::CMD_PLAIN_NIB) ? cmd_acc
                                                           : srtc_pkg::flip_byte(cmd_acc);
    cnt_live  = (cnt_r < srtc_pkg::CNT_W'(srtc_pkg::LATCH_BITS));

    if (hit) begin
      if (item.action) begin
        dir_nxt = item.write_value[4];
        pin_nxt = val;
        unique case (phase_r)
          srtc_pkg::PH_IDLE: begin
            if (cs_rise) begin
              phase_nxt = srtc_pkg::PH_COMMAND;
              cnt_nxt   = '0;
              cmd_nxt   = 8'h00;
              latch_nxt = '0;
            end
          end
          srtc_pkg::PH_COMMAND: begin
            if (sck_fall) begin
              if (cnt_r[2:0] == 3'd7) begin
                cnt_nxt = '0;
                cmd_nxt = cmd_fin;
                if (cmd_fin[0]) begin
                  phase_nxt = srtc_pkg::PH_READ;
                  unique case (cmd_fin[3:1])
                    srtc_pkg::REG_CONTROL:
                      latch_nxt = {{(srtc_pkg::LATCH_BITS-8){1'b0}}, ctrl_r};
                    srtc_pkg::REG_DATETIME:
                      latch_nxt = {{(srtc_pkg::LATCH_BITS-56){1'b0}},
                                   words.time_word, words.date_word};
                    srtc_pkg::REG_TIME:
                      latch_nxt = {{(srtc_pkg::LATCH_BITS-24){1'b0}}, words.time_word};
                    srtc_pkg::REG_ZERO:
                      latch_nxt = '0;
                    default: latch_nxt = latch_r;
                  endcase
                end else begin
                  phase_nxt = srtc_pkg::PH_WRITE;
                end
              end else begin
                cnt_nxt = cnt_r + 1'b1;
                cmd_nxt = cmd_acc;
              end
            end
          end
          srtc_pkg::PH_READ: begin
            if (sck_fall) begin
              if (!item.write_value[4]) begin
                pin_nxt[0] = cnt_live & latch_r[cnt_r[srtc_pkg::IDX_W-1:0]];
              end
              if (cnt_live) begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            if (cs_fall) begin
              phase_nxt = srtc_pkg::PH_IDLE;
            end
          end
          srtc_pkg::PH_WRITE: begin
            if (sck_fall && cnt_live) begin
              latch_nxt[cnt_r[srtc_pkg::IDX_W-1:0]] =
                latch_r[cnt_r[srtc_pkg::IDX_W-1:0]] | val[0];
              cnt_nxt = cnt_r + 1'b1;
            end
            if (cs_fall) begin
              if (cmd_r[3:1] == srtc_pkg::REG_CONTROL) begin
                ctrl_nxt = latch_nxt[7:0] & srtc_pkg::CTRL_MASK;
              end
              phase_nxt = srtc_pkg::PH_IDLE;
            end
          end
        endcase
      end else begin
        rd = pin_r & (dir_r ? 8'hFE : 8'hFF);
      end
    end
    result.read_data       = rd;
    result.transfer_active = (phase_nxt != srtc_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r   <= 8'h00;
      dir_r   <= 1'b0;
      phase_r <= srtc_pkg::PH_IDLE;
      cnt_r   <= '0;
      cmd_r   <= 8'h00;
      latch_r <= '0;
      ctrl_r  <= 8'h00;
    end else if (step) begin
      pin_r   <= pin_nxt;
      dir_r   <= dir_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
      latch_r <= latch_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

endmodule

@@ design/serial_rtc_gpio_slave.sv @@
// Top level of the serial RTC slave: input register, engine, result register.
// Depends on srtc_pkg, srtc_if, srtc_time_fmt and srtc_engine.
//
// Usage: in_ch carries one bus access to the I/O register per transfer,
// together with the current binary time. out_ch returns one result per
// access: the register byte for a read of the clock address (0 otherwise)
// and whether a serial transfer is in progress after the access.
// Path: an access that is taken passes through the input register and then
// the result register before its result is offered on out_ch.
// Throughput: one access per cycle while out_ch does not stall; the engine
// updates its state when an access moves from the input to the result register.
// Reset (rst_n low, synchronous) empties both registers, clears the pin
// register, control register, latch and counters and returns the serial
// state machine to idle.
// When out_ch stalls, the result register holds; the input register still
// takes one more access, after which in_ch.ready drops until out_ch moves.
`timescale 1ns / 1ps

module serial_rtc_gpio_slave (
  input  logic       clk,
  input  logic       rst_n,
  srtc_in_if.sink    in_ch,
  srtc_out_if.source out_ch
);

  logic                  s1_valid_r;
  srtc_pkg::in_item_t    s1_item_r;
  logic                  out_valid_r;
  srtc_pkg::out_item_t   out_item_r;
  logic                  advance;
  srtc_pkg::time_words_t words;
  srtc_pkg::out_item_t   res_nxt;
  logic                  mode_24h;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= '{action:      in_ch.action,
                     address:     in_ch.address,
                     write_value: in_ch.write_value,
                     year:        in_ch.year,
                     month:       in_ch.month,
                     day:         in_ch.day,
                     weekday:     in_ch.weekday,
                     hour:        in_ch.hour,
                     minute:      in_ch.minute,
                     second:      in_ch.second};
    end
    if (advance) begin
      out_item_r <= res_nxt;
    end
  end

  srtc_time_fmt u_time_fmt (
    .item     (s1_item_r),
    .mode_24h (mode_24h),
    .words    (words)
  );

  srtc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (s1_item_r),
    .words    (words),
    .mode_24h (mode_24h),
    .result   (res_nxt)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_item_r.read_data;
  assign out_ch.transfer_active = out_item_r.transfer_active;

endmodule

@@ design/srtc_checker.sv @@
// Port-level checker for the serial RTC slave, bound to the top level.
// Depends on serial_rtc_gpio_slave_assert.svh.
`timescale 1ns / 1ps
`include "serial_rtc_gpio_slave_assert.svh"

module srtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_transfer_active
);

  `SRTC_ASSERT_RESET(a_reset_empty, !out_valid && in_ready, "result pending after reset")
  `SRTC_ASSERT_IMPL(a_block_only_on_stall, !in_ready, out_valid && !out_ready, "input blocked without output stall")
  `SRTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result dropped")
  `SRTC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_read_data) && $stable(out_transfer_active), "stalled result changed")

endmodule

bind serial_rtc_gpio_slave srtc_checker u_srtc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_read_data       (out_ch.read_data),
  .out_transfer_active (out_ch.transfer_active)
);

@@ verif/tb_serial_rtc_gpio_slave.sv @@
// Testbench for serial_rtc_gpio_slave: drives bus accesses to the RTC pin register and
// checks every result against a cycle-free model of the three-wire slave kept in this file.
// Depends on srtc_pkg, srtc_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_serial_rtc_gpio_slave;
  import srtc_pkg::*;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam int   PIN_DATA  = 0;
  localparam int   PIN_SCK   = 1;
  localparam int   PIN_CS    = 2;
  localparam int   PIN_DIR   = 4;

  logic clk;
  logic rst_n;

  srtc_in_if  in_if ();
  srtc_out_if out_if ();

  serial_rtc_gpio_slave u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // model state of the slave
  logic [7:0]  pins;
  logic        host_drives;
  phase_t      phase;
  logic [6:0]  bit_cnt;
  logic [7:0]  cmd_byte;
  logic [63:0] bit_latch;
  logic [7:0]  ctrl_reg;

  out_item_t pending_results[$];
  int        mismatches;
  int        results_seen;
  int        accesses_sent;
  bit        calm;
  int        stall_left;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic logic [7:0] bcd_byte(input int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  task automatic predict_access(input in_item_t a, output out_item_t r);
    logic [7:0]  prev;
    logic [7:0]  v;
    logic        cs_rise;
    logic        cs_fall;
    logic        sck_fall;
    logic [2:0]  wd;
    logic [7:0]  hour_byte;
    logic [31:0] date_word;
    logic [23:0] time_word;
    int unsigned hr_mod;
    r = '0;
    if (a.address == RTC_ADDR) begin
      if (a.action == ACT_WRITE) begin
        v = a.write_value;
        host_drives = v[PIN_DIR];
        prev = pins;
        if (!host_drives) v[PIN_DATA] = prev[PIN_DATA];
        pins = v;
        cs_rise  = !prev[PIN_CS] && v[PIN_CS];
        cs_fall  = prev[PIN_CS] && !v[PIN_CS];
        sck_fall = prev[PIN_SCK] && !v[PIN_SCK];
        case (phase)
          PH_IDLE: begin
            if (cs_rise) begin
              phase = PH_COMMAND;
              bit_cnt = '0;
              cmd_byte = '0;
              bit_latch = '0;
            end
          end
          PH_COMMAND: begin
            if (sck_fall) begin
              cmd_byte[bit_cnt[2:0]] = cmd_byte[bit_cnt[2:0]] | pins[PIN_DATA];
              bit_cnt = bit_cnt + 1;
              if (bit_cnt >= 8) begin
                bit_cnt = '0;
                if (cmd_byte[7:4] != CMD_PLAIN_NIB) cmd_byte = {<<{cmd_byte}};
                wd = a.weekday;
                if (wd == WEEKDAY_SUNDAY) wd = WEEKDAY_REMAP;
                date_word = {5'b0, wd, bcd_byte(a.day), bcd_byte(a.month), bcd_byte(a.year)};
                hr_mod = ctrl_reg[1] ? HOURS_24 : HOURS_12;
                hour_byte = bcd_byte(a.hour % hr_mod);
                hour_byte[7] = hour_byte[7] | (((a.hour / HOURS_12) % 2) != 0);
                time_word = {bcd_byte(a.second), bcd_byte(a.minute), hour_byte};
                if (cmd_byte[0]) begin
                  case (cmd_byte[3:1])
                    REG_CONTROL:  bit_latch = {56'b0, ctrl_reg};
                    REG_DATETIME: bit_latch = {8'b0, time_word, date_word};
                    REG_TIME:     bit_latch = {40'b0, time_word};
                    REG_ZERO:     bit_latch = '0;
                    default: ;
                  endcase
                  phase = PH_READ;
                end else begin
                  phase = PH_WRITE;
                end
              end
            end
          end
          PH_READ: begin
            if (sck_fall) begin
              if (!host_drives) begin
                pins[PIN_DATA] = (bit_cnt < LATCH_BITS) ? bit_latch[bit_cnt[5:0]] : 1'b0;
              end
              if (bit_cnt < LATCH_BITS) bit_cnt = bit_cnt + 1;
            end
            if (cs_fall) phase = PH_IDLE;
          end
          default: begin
            if (sck_fall) begin
              if (bit_cnt < LATCH_BITS) begin
                bit_latch[bit_cnt[5:0]] = bit_latch[bit_cnt[5:0]] | pins[PIN_DATA];
                bit_cnt = bit_cnt + 1;
              end
            end
            if (cs_fall) begin
              if (cmd_byte[3:1] == REG_CONTROL) ctrl_reg = bit_latch[7:0] & CTRL_MASK;
              phase = PH_IDLE;
            end
          end
        endcase
      end else begin
        r.read_data = pins & (host_drives ? 8'hFE : 8'hFF);
      end
    end
    r.transfer_active = (phase != PH_IDLE);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH result %0d %s: got %0h, want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_if.read_data, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (out_if.read_data !== want.read_data)
          report_mismatch("read_data", out_if.read_data, want.read_data);
        if (out_if.transfer_active !== want.transfer_active)
          report_mismatch("transfer_active", 8'(out_if.transfer_active),
                          8'(want.transfer_active));
      end
      results_seen++;
    end
  end

  // result side: random stall bursts, none while calm
  initial begin
    out_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_if.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic in_item_t make_access(input logic act, input logic [7:0] v);
    in_item_t a;
    a.action = act;
    a.address = RTC_ADDR;
    a.write_value = v;
    if ($urandom_range(0, 4) == 0) begin
      a.year    = 7'($urandom);
      a.month   = 4'($urandom);
      a.day     = 5'($urandom);
      a.weekday = 3'($urandom);
      a.hour    = 5'($urandom);
      a.minute  = 6'($urandom);
      a.second  = 6'($urandom);
    end else begin
      a.year    = 7'($urandom_range(0, 99));
      a.month   = 4'($urandom_range(1, 12));
      a.day     = 5'($urandom_range(1, 31));
      a.weekday = 3'($urandom_range(0, 6));
      a.hour    = 5'($urandom_range(0, 23));
      a.minute  = 6'($urandom_range(0, 59));
      a.second  = 6'($urandom_range(0, 59));
    end
    return a;
  endfunction

  function automatic logic [7:0] pin_byte(input logic d, input logic sck, input logic cs,
                                          input logic dir);
    logic [7:0] v;
    v = 8'($urandom);
    v[PIN_DATA] = d;
    v[PIN_SCK]  = sck;
    v[PIN_CS]   = cs;
    v[PIN_DIR]  = dir;
    return v;
  endfunction

  // enter and leave on a falling edge; valid stays high for the next access
  task automatic send_access(input in_item_t a);
    out_item_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.action      = a.action;
    in_if.address     = a.address;
    in_if.write_value = a.write_value;
    in_if.year        = a.year;
    in_if.month       = a.month;
    in_if.day         = a.day;
    in_if.weekday     = a.weekday;
    in_if.hour        = a.hour;
    in_if.minute      = a.minute;
    in_if.second      = a.second;
    do @(posedge clk); while (!in_if.ready);
    predict_access(a, r);
    pending_results.push_back(r);
    accesses_sent++;
    @(negedge clk);
  endtask

  task automatic pin_write(input logic [7:0] v);
    send_access(make_access(ACT_WRITE, v));
  endtask

  task automatic hold_until_drained();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic begin_transfer();
    pin_write(pin_byte(1'($urandom), 1'b1, 1'b0, 1'b1));
    pin_write(pin_byte(1'($urandom), 1'b1, 1'b1, 1'b1));
  endtask

  task automatic end_transfer();
    pin_write(pin_byte(1'($urandom), 1'b1, 1'b0, 1'($urandom)));
  endtask

  task automatic send_command(input logic [7:0] raw);
    for (int i = 0; i < 8; i++) begin
      pin_write(pin_byte(raw[i], 1'b1, 1'b1, 1'b1));
      pin_write(pin_byte(raw[i], 1'b0, 1'b1, 1'b1));
    end
  endtask

  // plain form with the 0110 prefix, or the bit-reversed form with a random nibble
  function automatic logic [7:0] command_for(input logic [2:0] sel, input logic rd);
    logic [7:0] c;
    c = {4'($urandom), sel, rd};
    if ($urandom_range(0, 1) == 0) return {CMD_PLAIN_NIB, sel, rd};
    return {<<{c}};
  endfunction

  task automatic write_register(input int nbits, input logic [2:0] sel);
    logic d;
    begin_transfer();
    send_command(command_for(sel, 1'b0));
    repeat (nbits) begin
      d = 1'($urandom);
      pin_write(pin_byte(d, 1'b1, 1'b1, 1'b1));
      pin_write(pin_byte(d, 1'b0, 1'b1, 1'b1));
    end
    end_transfer();
  endtask

  task automatic read_register(input logic [7:0] raw, input int nbits);
    logic dir;
    begin_transfer();
    send_command(raw);
    repeat (nbits) begin
      dir = ($urandom_range(0, 9) == 0);
      pin_write(pin_byte(1'($urandom), 1'b1, 1'b1, dir));
      pin_write(pin_byte(1'($urandom), 1'b0, 1'b1, dir));
      send_access(make_access(ACT_READ, 8'($urandom)));
    end
    end_transfer();
  endtask

  task automatic test_bus_access();
    in_item_t a;
    a = make_access(ACT_READ, 8'hFF);
    a.address = 32'h0000_0000;
    send_access(a);
    a = make_access(ACT_WRITE, 8'hFF);
    a.address = 32'hFFFF_FFFF;
    send_access(a);
    a = make_access(ACT_WRITE, 8'hFF);
    a.address = RTC_ADDR ^ 32'h1;
    send_access(a);
    a = make_access(ACT_WRITE, 8'h00);
    {a.year, a.month, a.day, a.weekday, a.hour, a.minute, a.second} = '0;
    send_access(a);
    a = make_access(ACT_WRITE, 8'hFF);
    {a.year, a.month, a.day, a.weekday, a.hour, a.minute, a.second} = '1;
    send_access(a);
    send_access(make_access(ACT_READ, 8'h00));
    // select drops mid-command with the pin in input direction: ignored
    pin_write(8'hEB);
    send_access(make_access(ACT_READ, 8'h00));
    pin_write(8'h00);
    send_access(make_access(ACT_READ, 8'hFF));
    send_command(8'($urandom));
    end_transfer();
  endtask

  task automatic test_control_write();
    repeat (10) begin
      write_register($urandom_range(1, 12),
                     ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : REG_CONTROL);
    end
    write_register($urandom_range(65, 72), REG_CONTROL);
  endtask

  task automatic test_register_read();
    int         pick;
    logic [2:0] sel;
    logic [7:0] raw;
    while (accesses_sent < 1000) begin
      if ($urandom_range(0, 2) == 0) write_register($urandom_range(2, 5), REG_CONTROL);
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: sel = REG_DATETIME;
        4, 5:       sel = REG_TIME;
        6:          sel = REG_CONTROL;
        7:          sel = REG_ZERO;
        default:    sel = 3'($urandom);
      endcase
      raw = ($urandom_range(0, 9) == 0) ? 8'($urandom) : command_for(sel, 1'b1);
      read_register(raw, ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72)
                                                      : $urandom_range(4, 24));
    end
  endtask

  task automatic test_noise();
    in_item_t a;
    int       pick;
    repeat (250) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        a = in_item_t'({$urandom, $urandom, $urandom});
        if ($urandom_range(0, 1) == 0) a.address = RTC_ADDR;
        send_access(a);
      end else if (pick == 2) begin
        send_access(make_access(ACT_READ, 8'($urandom)));
      end else begin
        pin_write(8'($urandom));
      end
    end
    read_register(8'($urandom), 3);
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      read_register(command_for(REG_TIME, 1'b1), 4);
      hold_until_drained();
    end
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    read_register(command_for(REG_DATETIME, 1'b1), 40);
    write_register(6, REG_CONTROL);
    read_register(command_for(REG_TIME, 1'b1), 12);
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    results_seen = 0;
    accesses_sent = 0;
    pins = '0;
    host_drives = 1'b0;
    phase = PH_IDLE;
    bit_cnt = '0;
    cmd_byte = '0;
    bit_latch = '0;
    ctrl_reg = '0;
    in_if.valid = 1'b0;
    in_if.action = ACT_READ;
    in_if.address = '0;
    in_if.write_value = '0;
    in_if.year = '0;
    in_if.month = '0;
    in_if.day = '0;
    in_if.weekday = '0;
    in_if.hour = '0;
    in_if.minute = '0;
    in_if.second = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_bus_access();
    test_control_write();
    test_register_read();
    test_noise();
    test_drain_pause();
    test_steady_stream();

    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
